// ===== hdl/ddo_pkg.sv =====
`default_nettype none
package ddo_pkg;

	localparam int ATAN_ENTRIES = 30;
	localparam int OP_W = 34;
	localparam int PROD_W = 2 * OP_W;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [OP_W-1:0] PI_Q29 = 34'sd1686629713;
	localparam logic signed [OP_W-1:0] HALF_PI_Q29 = 34'sd843314857;
	localparam logic signed [OP_W-1:0] TWO_PI_Q29 = 34'sd3373259426;
	localparam logic signed [OP_W-1:0] ONE_Q29 = 34'sd536870912;
	localparam logic signed [OP_W-1:0] INV_GAIN_Q29 = 34'sd326016437;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIST_PER_COUNT = 3'd0,
		CFG_WHEEL_BASE = 3'd1,
		CFG_STRAIGHT_THR = 3'd2,
		CFG_MOVE_LIMIT = 3'd3,
		CFG_ANGLE_LIMIT = 3'd4
	} cfg_idx_t;

	function automatic logic [29:0] atan_q29(input logic [4:0] i);
		case (i)
			5'd0: atan_q29 = 30'd421657428;
			5'd1: atan_q29 = 30'd248918915;
			5'd2: atan_q29 = 30'd131521918;
			5'd3: atan_q29 = 30'd66762579;
			5'd4: atan_q29 = 30'd33510843;
			5'd5: atan_q29 = 30'd16771758;
			5'd6: atan_q29 = 30'd8387925;
			5'd7: atan_q29 = 30'd4194219;
			5'd8: atan_q29 = 30'd2097141;
			5'd9: atan_q29 = 30'd1048575;
			default: atan_q29 = 30'd1 << (5'd29 - i);
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== hdl/ddo_if.sv =====
`default_nettype none
interface ddo_sample_if import ddo_pkg::*;;
	logic valid;
	logic ready;
	logic command;
	logic signed [31:0] left_count;
	logic signed [31:0] right_count;
	logic signed [31:0] load_x;
	logic signed [31:0] load_y;
	logic signed [31:0] load_heading;

	modport source (output valid, command, left_count, right_count, load_x, load_y,
		load_heading, input ready);
	modport sink (input valid, command, left_count, right_count, load_x, load_y,
		load_heading, output ready);
endinterface

interface ddo_result_if import ddo_pkg::*;;
	logic valid;
	logic ready;
	logic signed [31:0] pose_x;
	logic signed [31:0] pose_y;
	logic signed [31:0] pose_heading;
	logic signed [31:0] step_dx;
	logic signed [31:0] step_dy;
	logic signed [31:0] step_dheading;
	logic moved_enough;

	modport source (output valid, pose_x, pose_y, pose_heading, step_dx, step_dy,
		step_dheading, moved_enough, input ready);
	modport sink (input valid, pose_x, pose_y, pose_heading, step_dx, step_dy,
		step_dheading, moved_enough, output ready);
endinterface

interface ddo_cfg_if import ddo_pkg::*;;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/ddo_mul.sv =====
`default_nettype none
module ddo_mul import ddo_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [OP_W-1:0] a,
	input wire logic signed [OP_W-1:0] b,
	output logic busy,
	output logic done,
	output logic signed [PROD_W-1:0] p
);
	localparam int CNT_W = $clog2(OP_W);

	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] mcand_q;
	logic [OP_W-1:0] mplier_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(OP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The top bit of the multiplier carries negative weight.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mcand_q <= PROD_W'(a);
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				if (cnt_q == CNT_W'(OP_W - 1)) begin
					acc_q <= acc_q - mcand_q;
				end else begin
					acc_q <= acc_q + mcand_q;
				end
			end
			mcand_q <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign p = acc_q;
endmodule
`default_nettype wire

// ===== hdl/ddo_div.sv =====
`default_nettype none
module ddo_div import ddo_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [63:0] num,
	input wire logic [31:0] den,
	output logic done,
	output logic [63:0] quot
);
	logic [63:0] num_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [32:0] trial;
	logic fits;

	assign trial = {rem_q, num_q[63]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			num_q <= {num_q[62:0], fits};
		end
	end

	assign done = done_q;
	assign quot = num_q;
endmodule
`default_nettype wire

// ===== hdl/ddo_sqrt.sv =====
`default_nettype none
module ddo_sqrt import ddo_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [63:0] rad,
	output logic done,
	output logic [31:0] root
);
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [35:0] trial;
	logic [35:0] sub;
	logic fits;

	assign trial = {rem_q, rad_q[63:62]};
	assign sub = {2'b00, root_q, 2'b01};
	assign fits = trial >= sub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= rad;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			rem_q <= fits ? 34'(trial - sub) : trial[33:0];
			root_q <= {root_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

// ===== hdl/ddo_cordic.sv =====
`default_nettype none
module ddo_cordic import ddo_pkg::*; #(
	parameter int STEPS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [31:0] angle,
	output logic done,
	output logic signed [OP_W-1:0] cos_o,
	output logic signed [OP_W-1:0] sin_o
);
	logic signed [OP_W-1:0] x_q;
	logic signed [OP_W-1:0] y_q;
	logic signed [OP_W-1:0] z_q;
	logic signed [OP_W-1:0] z_in;
	logic signed [OP_W-1:0] xs;
	logic signed [OP_W-1:0] ys;
	logic signed [OP_W-1:0] step_ang;
	logic neg_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;

	assign z_in = OP_W'(angle);
	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign step_ang = OP_W'(signed'({1'b0, atan_q29(cnt_q)}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Angles beyond a quarter turn are folded by half a turn and the results negated.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= INV_GAIN_Q29;
			y_q <= '0;
			if (z_in > HALF_PI_Q29) begin
				z_q <= z_in - PI_Q29;
				neg_q <= 1'b1;
			end else if (z_in < -HALF_PI_Q29) begin
				z_q <= z_in + PI_Q29;
				neg_q <= 1'b1;
			end else begin
				z_q <= z_in;
				neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (!z_q[OP_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - step_ang;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + step_ang;
			end
		end
	end

	assign done = done_q;
	assign cos_o = neg_q ? -x_q : x_q;
	assign sin_o = neg_q ? -y_q : y_q;
endmodule
`default_nettype wire

// ===== hdl/differential_drive_odometry_top.sv =====
// Wheel odometry for a differential drive. Each sample item carries absolute encoder counts
// and yields the updated pose, the robot-frame step and the moved flag; a load item sets
// the pose. The time a sample takes is set by the single shared bit-serial multiplier (up to
// ten products), the shared restoring divider (up to three quotients), the iterative CORDIC
// (once or twice) and a 32-step square root. One item is worked on at a time; a finished
// result waits in the output register while the next item is taken in.
`default_nettype none
module differential_drive_odometry_top import ddo_pkg::*; #(
	parameter int CORDIC_STEPS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	ddo_sample_if.sink sample,
	ddo_result_if.source result,
	ddo_cfg_if.sink cfg
);
	typedef enum logic [4:0] {
		ST_IDLE, ST_MUL_L, ST_MUL_R, ST_DIV_T, ST_ARC, ST_COR_T, ST_MUL_SA, ST_DIV_SA,
		ST_MUL_SB, ST_DIV_SB, ST_COR_H, ST_MUL_XC, ST_MUL_YS, ST_MUL_XS, ST_MUL_YC,
		ST_MUL_XX, ST_MUL_YY, ST_SQRT, ST_DONE
	} state_t;

	state_t state_q;
	logic go_q;
	logic cmd_q;

	logic [31:0] dpc_q;
	logic [30:0] wb_q;
	logic [29:0] thr_q;
	logic [31:0] mlimit_q;
	logic [31:0] alimit_q;

	logic [31:0] last_l_q, last_r_q;
	logic signed [31:0] wx_q, wy_q, wh_q;
	logic [31:0] travel_q, turn_q;
	logic signed [31:0] delta_l_q, delta_r_q;
	logic signed [31:0] dl_q, dr_q, dt_q, dx_q, dy_q;
	logic [30:0] mag_q;
	logic signed [PROD_W-1:0] acc_q;
	logic [31:0] root_q;

	logic out_valid_q;
	logic signed [31:0] ox_q, oy_q, oh_q, odx_q, ody_q, odt_q;
	logic oflag_q;

	logic mul_start, mul_busy, mul_done;
	logic signed [OP_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic div_start, div_done;
	logic [63:0] div_num, div_quot;
	logic [31:0] div_den;
	logic cor_start, cor_done;
	logic signed [31:0] cor_ang;
	logic signed [OP_W-1:0] cor_c, cor_s;
	logic sq_start, sq_done;
	logic [31:0] sq_root;

	logic is_mul, is_div, is_cor;
	logic signed [32:0] diff_lr;
	logic [32:0] diff_mag;
	logic signed [32:0] mean_sum;
	logic signed [31:0] mean;
	logic signed [PROD_W-1:0] p_mag;
	logic quot_neg;
	logic [30:0] dt_q_mag;
	logic signed [PROD_W-1:0] wheel_shift;
	logic signed [PROD_W-1:0] off_x, off_y;
	logic signed [OP_W-1:0] h_sum, h_wrap;
	logic [32:0] travel_add, turn_add;
	logic [31:0] travel_new, turn_new;
	logic flag_new;
	logic out_free;

	function automatic logic signed [31:0] sat_quot(input logic [63:0] q, input logic neg);
		if (neg) begin
			sat_quot = (q > 64'h8000_0000) ? 32'sh8000_0000 : -signed'(q[31:0]);
		end else begin
			sat_quot = (q > 64'h7fff_ffff) ? 32'sh7fff_ffff : signed'(q[31:0]);
		end
	endfunction

	ddo_mul u_mul (.clk, .arst_n, .start(mul_start), .a(mul_a), .b(mul_b), .busy(mul_busy),
		.done(mul_done), .p(mul_p));
	ddo_div u_div (.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quot(div_quot));
	ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (.clk, .arst_n, .start(cor_start),
		.angle(cor_ang), .done(cor_done), .cos_o(cor_c), .sin_o(cor_s));
	ddo_sqrt u_sqrt (.clk, .arst_n, .start(sq_start), .rad(acc_q[63:0]), .done(sq_done),
		.root(sq_root));

	assign cfg.ready = 1'b1;
	assign sample.ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || result.ready;

	assign diff_lr = 33'(dr_q) - 33'(dl_q);
	assign diff_mag = diff_lr[32] ? 33'(-diff_lr) : 33'(diff_lr);
	assign mean_sum = 33'(dl_q) + 33'(dr_q);
	assign mean = mean_sum[32:1];
	assign p_mag = mul_p[PROD_W-1] ? -mul_p : mul_p;
	assign quot_neg = mul_p[PROD_W-1] ^ dt_q[31];
	assign dt_q_mag = (div_quot > 64'(PI_Q29)) ? 31'(PI_Q29) : div_quot[30:0];
	assign wheel_shift = mul_p >>> 16;
	assign off_x = acc_q - mul_p;
	assign off_y = acc_q + mul_p;

	assign is_mul = (state_q == ST_MUL_L) || (state_q == ST_MUL_R) || (state_q == ST_MUL_SA)
		|| (state_q == ST_MUL_SB) || (state_q == ST_MUL_XC) || (state_q == ST_MUL_YS)
		|| (state_q == ST_MUL_XS) || (state_q == ST_MUL_YC) || (state_q == ST_MUL_XX)
		|| (state_q == ST_MUL_YY);
	assign is_div = (state_q == ST_DIV_T) || (state_q == ST_DIV_SA) || (state_q == ST_DIV_SB);
	assign is_cor = (state_q == ST_COR_T) || (state_q == ST_COR_H);
	assign mul_start = is_mul && !go_q;
	assign div_start = is_div && !go_q;
	assign cor_start = is_cor && !go_q;
	assign sq_start = (state_q == ST_SQRT) && !go_q;
	assign cor_ang = (state_q == ST_COR_T) ? dt_q : wh_q;

	always_comb begin
		mul_a = OP_W'(dx_q);
		mul_b = cor_c;
		case (state_q)
			ST_MUL_L: begin
				mul_a = OP_W'(delta_l_q);
				mul_b = OP_W'({2'b00, dpc_q});
			end
			ST_MUL_R: begin
				mul_a = OP_W'(delta_r_q);
				mul_b = OP_W'({2'b00, dpc_q});
			end
			ST_MUL_SA: begin
				mul_a = OP_W'(mean);
				mul_b = cor_s;
			end
			ST_MUL_SB: begin
				mul_a = OP_W'(mean);
				mul_b = ONE_Q29 - cor_c;
			end
			ST_MUL_YS: begin
				mul_a = OP_W'(dy_q);
				mul_b = cor_s;
			end
			ST_MUL_XS: begin
				mul_a = OP_W'(dx_q);
				mul_b = cor_s;
			end
			ST_MUL_YC: begin
				mul_a = OP_W'(dy_q);
				mul_b = cor_c;
			end
			ST_MUL_XX: begin
				mul_a = OP_W'(dx_q);
				mul_b = OP_W'(dx_q);
			end
			ST_MUL_YY: begin
				mul_a = OP_W'(dy_q);
				mul_b = OP_W'(dy_q);
			end
			default: begin
				mul_a = OP_W'(dx_q);
				mul_b = cor_c;
			end
		endcase
	end

	always_comb begin
		if (state_q == ST_DIV_T) begin
			div_num = {2'b00, diff_mag, 29'd0};
			div_den = (wb_q == '0) ? 32'd1 : {1'b0, wb_q};
		end else begin
			div_num = p_mag[63:0];
			div_den = {1'b0, mag_q};
		end
	end

	assign h_sum = OP_W'(wh_q) + OP_W'(dt_q);
	always_comb begin
		if (h_sum > PI_Q29) begin
			h_wrap = h_sum - TWO_PI_Q29;
		end else if (h_sum < -PI_Q29) begin
			h_wrap = h_sum + TWO_PI_Q29;
		end else begin
			h_wrap = h_sum;
		end
	end

	assign travel_add = {1'b0, travel_q} + {1'b0, root_q};
	assign turn_add = {1'b0, turn_q} + {2'b00, mag_q};
	assign travel_new = travel_add[32] ? '1 : travel_add[31:0];
	assign turn_new = turn_add[32] ? '1 : turn_add[31:0];
	assign flag_new = (travel_new > mlimit_q) || (turn_new > alimit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q <= 32'd4294967;
			wb_q <= 31'd33554432;
			thr_q <= 30'd912680;
			mlimit_q <= 32'd6553600;
			alimit_q <= 32'd268435456;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_DIST_PER_COUNT: dpc_q <= cfg.data;
				CFG_WHEEL_BASE: wb_q <= cfg.data[30:0];
				CFG_STRAIGHT_THR: thr_q <= cfg.data[29:0];
				CFG_MOVE_LIMIT: mlimit_q <= cfg.data;
				CFG_ANGLE_LIMIT: alimit_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q <= 1'b0;
			cmd_q <= 1'b0;
			last_l_q <= '0;
			last_r_q <= '0;
			wx_q <= '0;
			wy_q <= '0;
			wh_q <= '0;
			travel_q <= '0;
			turn_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (is_mul || is_div || is_cor || state_q == ST_SQRT) begin
				if (!go_q) begin
					go_q <= 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						cmd_q <= sample.command;
						if (sample.command) begin
							wx_q <= sample.load_x;
							wy_q <= sample.load_y;
							wh_q <= sample.load_heading;
							state_q <= ST_DONE;
						end else begin
							delta_l_q <= sample.left_count - signed'(last_l_q);
							delta_r_q <= sample.right_count - signed'(last_r_q);
							last_l_q <= sample.left_count;
							last_r_q <= sample.right_count;
							state_q <= ST_MUL_L;
						end
					end
				end
				ST_MUL_L, ST_MUL_R: begin
					if (go_q && mul_done) begin
						go_q <= 1'b0;
						if (state_q == ST_MUL_L) begin
							dl_q <= sat_quot(wheel_shift[PROD_W-1] ? 64'(-wheel_shift)
								: 64'(wheel_shift), wheel_shift[PROD_W-1]);
							state_q <= ST_MUL_R;
						end else begin
							dr_q <= sat_quot(wheel_shift[PROD_W-1] ? 64'(-wheel_shift)
								: 64'(wheel_shift), wheel_shift[PROD_W-1]);
							state_q <= ST_DIV_T;
						end
					end
				end
				ST_DIV_T: begin
					if (go_q && div_done) begin
						go_q <= 1'b0;
						mag_q <= dt_q_mag;
						dt_q <= diff_lr[32] ? -signed'({1'b0, dt_q_mag}) : {1'b0, dt_q_mag};
						state_q <= ST_ARC;
					end
				end
				ST_ARC: begin
					if (mag_q != '0 && mag_q >= {1'b0, thr_q}) begin
						state_q <= ST_COR_T;
					end else begin
						dx_q <= mean;
						dy_q <= '0;
						state_q <= ST_COR_H;
					end
				end
				ST_COR_T, ST_COR_H: begin
					if (go_q && cor_done) begin
						go_q <= 1'b0;
						state_q <= (state_q == ST_COR_T) ? ST_MUL_SA : ST_MUL_XC;
					end
				end
				ST_MUL_SA, ST_MUL_SB: begin
					if (go_q && mul_done) begin
						go_q <= 1'b0;
						state_q <= (state_q == ST_MUL_SA) ? ST_DIV_SA : ST_DIV_SB;
					end
				end
				ST_DIV_SA, ST_DIV_SB: begin
					if (go_q && div_done) begin
						go_q <= 1'b0;
						if (state_q == ST_DIV_SA) begin
							dx_q <= sat_quot(div_quot, quot_neg);
							state_q <= ST_MUL_SB;
						end else begin
							dy_q <= sat_quot(div_quot, quot_neg);
							state_q <= ST_COR_H;
						end
					end
				end
				ST_MUL_XC, ST_MUL_XS, ST_MUL_XX: begin
					if (go_q && mul_done) begin
						go_q <= 1'b0;
						acc_q <= mul_p;
						state_q <= (state_q == ST_MUL_XC) ? ST_MUL_YS
							: (state_q == ST_MUL_XS) ? ST_MUL_YC : ST_MUL_YY;
					end
				end
				ST_MUL_YS: begin
					if (go_q && mul_done) begin
						go_q <= 1'b0;
						wx_q <= wx_q + off_x[60:29];
						state_q <= ST_MUL_XS;
					end
				end
				ST_MUL_YC: begin
					if (go_q && mul_done) begin
						go_q <= 1'b0;
						wy_q <= wy_q + off_y[60:29];
						state_q <= ST_MUL_XX;
					end
				end
				ST_MUL_YY: begin
					if (go_q && mul_done) begin
						go_q <= 1'b0;
						acc_q <= off_y;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (go_q && sq_done) begin
						go_q <= 1'b0;
						root_q <= sq_root;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						ox_q <= wx_q;
						oy_q <= wy_q;
						if (cmd_q) begin
							oh_q <= wh_q;
							odx_q <= '0;
							ody_q <= '0;
							odt_q <= '0;
							oflag_q <= 1'b0;
						end else begin
							oh_q <= h_wrap[31:0];
							wh_q <= h_wrap[31:0];
							odx_q <= dx_q;
							ody_q <= dy_q;
							odt_q <= dt_q;
							oflag_q <= flag_new;
							travel_q <= flag_new ? '0 : travel_new;
							turn_q <= flag_new ? '0 : turn_new;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.pose_x = ox_q;
	assign result.pose_y = oy_q;
	assign result.pose_heading = oh_q;
	assign result.step_dx = odx_q;
	assign result.step_dy = ody_q;
	assign result.step_dheading = odt_q;
	assign result.moved_enough = oflag_q;

	a_load_short: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready && sample.command) |=> (state_q == ST_DONE))
		else $error("A load item did not go straight to completion.");

	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy)
		else $error("The multiplier was started while busy.");

	a_dt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ARC) |-> (OP_W'(dt_q) <= PI_Q29 && OP_W'(dt_q) >= -PI_Q29))
		else $error("Heading change left the half-turn range.");

	a_flag_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && oflag_q) |-> (travel_q == '0 && turn_q == '0))
		else $error("Sums not cleared with the moved flag.");
endmodule
`default_nettype wire

// ===== verif/ddo_tb_if.sv =====
`timescale 1ns / 100ps
// The channel interfaces are defined with the block in hdl/ddo_if.sv; this file holds only
// the testbench package, which sets RUN_ITEMS.
package ddo_tb_pkg;
	localparam int RUN_ITEMS = 1600;
endpackage

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
module tb;
	import ddo_pkg::*;
	import ddo_tb_pkg::*;

	typedef struct packed {
		logic command;
		logic [31:0] left_count;
		logic [31:0] right_count;
		logic [31:0] load_x;
		logic [31:0] load_y;
		logic [31:0] load_heading;
	} odo_item_t;

	typedef struct packed {
		logic [31:0] pose_x;
		logic [31:0] pose_y;
		logic [31:0] pose_heading;
		logic [31:0] step_dx;
		logic [31:0] step_dy;
		logic [31:0] step_dheading;
		logic moved_enough;
	} odo_pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ddo_sample_if sample ();
	ddo_result_if result ();
	ddo_cfg_if cfg ();

	differential_drive_odometry_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample.sink),
		.result(result.source),
		.cfg(cfg.sink)
	);

	always #4 clk = ~clk;

	odo_item_t pending_items[$];
	odo_pose_t expected_poses[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit failed = 0;
	bit hold_off = 0;
	int quiet_cycles = 0;
	bit cfg_pending = 0;
	logic [2:0] cfg_index_q;
	logic [31:0] cfg_data_q;

	// Predictor state and registers.
	logic [31:0] p_dist_per_count, p_wheel_base, p_straight_thr, p_move_limit, p_angle_limit;
	logic [31:0] p_last_left, p_last_right, p_x, p_y, p_heading, p_travel, p_turn;

	function automatic longint shift_down(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint atan_entry(int i);
		longint t[10] = '{421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
			8387925, 4194219, 2097141, 1048575};
		if (i < 10) return t[i];
		return longint'(1) << (29 - i);
	endfunction

	task automatic rotate_unit(input longint ang, output longint c, output longint s);
		longint x, y, z, xs, ys;
		bit neg;
		x = 326016437;
		y = 0;
		z = ang;
		neg = 0;
		if (z > 843314857) begin
			z -= 1686629713;
			neg = 1;
		end else if (z < -843314857) begin
			z += 1686629713;
			neg = 1;
		end
		for (int i = 0; i < 24; i++) begin
			xs = shift_down(x, i);
			ys = shift_down(y, i);
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= atan_entry(i);
			end else begin
				x += ys;
				y -= xs;
				z += atan_entry(i);
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endtask

	function automatic longint root_floor(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint wheel_travel(logic [31:0] now, logic [31:0] prev);
		logic [31:0] d;
		d = now - prev;
		return clamp32(shift_down(longint'($signed(d)) * longint'({32'd0, p_dist_per_count}), 16));
	endfunction

	task automatic predict_pose(input odo_item_t it);
		odo_pose_t r;
		longint dx, dy, dt, dl, dr, mean, wb, mag, c, s, h, ox, oy, root;
		logic [32:0] sum;
		dx = 0;
		dy = 0;
		dt = 0;
		r.moved_enough = 0;
		if (it.command) begin
			p_x = it.load_x;
			p_y = it.load_y;
			p_heading = it.load_heading;
		end else begin
			dl = wheel_travel(it.left_count, p_last_left);
			dr = wheel_travel(it.right_count, p_last_right);
			mean = shift_down(dl + dr, 1);
			wb = (p_wheel_base == 0) ? 1 : longint'(p_wheel_base);
			p_last_left = it.left_count;
			p_last_right = it.right_count;
			dt = ((dr - dl) * 536870912) / wb;
			if (dt > 1686629713) dt = 1686629713;
			if (dt < -1686629713) dt = -1686629713;
			mag = dt < 0 ? -dt : dt;
			if (dt != 0 && mag >= longint'(p_straight_thr)) begin
				rotate_unit(dt, c, s);
				dx = clamp32((mean * s) / dt);
				dy = clamp32((mean * (536870912 - c)) / dt);
			end else begin
				dx = mean;
				dy = 0;
			end
			h = longint'($signed(p_heading));
			rotate_unit(h, c, s);
			ox = shift_down(dx * c - dy * s, 29);
			oy = shift_down(dx * s + dy * c, 29);
			p_x = p_x + ox[31:0];
			p_y = p_y + oy[31:0];
			h += dt;
			if (h > 1686629713) h -= 3373259426;
			else if (h < -1686629713) h += 3373259426;
			p_heading = h[31:0];
			root = root_floor(dx * dx + dy * dy);
			sum = {1'b0, p_travel} + {1'b0, root[31:0]};
			p_travel = sum[32] ? 32'hFFFFFFFF : sum[31:0];
			sum = {1'b0, p_turn} + {1'b0, mag[31:0]};
			p_turn = sum[32] ? 32'hFFFFFFFF : sum[31:0];
			if (p_travel > p_move_limit || p_turn > p_angle_limit) begin
				r.moved_enough = 1;
				p_travel = 0;
				p_turn = 0;
			end
		end
		r.pose_x = p_x;
		r.pose_y = p_y;
		r.pose_heading = p_heading;
		r.step_dx = dx[31:0];
		r.step_dy = dy[31:0];
		r.step_dheading = dt[31:0];
		expected_poses.push_back(r);
	endtask

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample.valid <= 1'b0;
			sample.command <= 1'b0;
			sample.left_count <= '0;
			sample.right_count <= '0;
			sample.load_x <= '0;
			sample.load_y <= '0;
			sample.load_heading <= '0;
		end else if (!sample.valid || sample.ready) begin
			if (sample.valid) predict_pose({sample.command, sample.left_count, sample.right_count,
				sample.load_x, sample.load_y, sample.load_heading});
			if (pending_items.size() != 0 && !hold_off &&
				$urandom_range(99) >= send_idle_pct) begin
				odo_item_t it;
				it = pending_items.pop_front();
				sample.valid <= 1'b1;
				{sample.command, sample.left_count, sample.right_count, sample.load_x,
					sample.load_y, sample.load_heading} <= it;
			end else begin
				sample.valid <= 1'b0;
			end
		end
	end

	// Monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_poses.size() == 0) begin
					$error("unexpected result item");
					failed = 1;
				end else begin
					odo_pose_t e;
					e = expected_poses.pop_front();
					if (result.pose_x !== e.pose_x) begin
						$error("pose_x expected %h got %h", e.pose_x, result.pose_x);
						failed = 1;
					end
					if (result.pose_y !== e.pose_y) begin
						$error("pose_y expected %h got %h", e.pose_y, result.pose_y);
						failed = 1;
					end
					if (result.pose_heading !== e.pose_heading) begin
						$error("pose_heading expected %h got %h", e.pose_heading,
							result.pose_heading);
						failed = 1;
					end
					if (result.step_dx !== e.step_dx) begin
						$error("step_dx expected %h got %h", e.step_dx, result.step_dx);
						failed = 1;
					end
					if (result.step_dy !== e.step_dy) begin
						$error("step_dy expected %h got %h", e.step_dy, result.step_dy);
						failed = 1;
					end
					if (result.step_dheading !== e.step_dheading) begin
						$error("step_dheading expected %h got %h", e.step_dheading,
							result.step_dheading);
						failed = 1;
					end
					if (result.moved_enough !== e.moved_enough) begin
						$error("moved_enough expected %b got %b", e.moved_enough,
							result.moved_enough);
						failed = 1;
					end
				end
			end
			result.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Register writes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.valid <= 1'b0;
			cfg.index <= '0;
			cfg.data <= '0;
		end else if (cfg.valid && cfg.ready) begin
			cfg.valid <= 1'b0;
			case (cfg_idx_t'(cfg.index))
				CFG_DIST_PER_COUNT: p_dist_per_count = cfg.data;
				CFG_WHEEL_BASE: p_wheel_base = {1'b0, cfg.data[30:0]};
				CFG_STRAIGHT_THR: p_straight_thr = {2'b0, cfg.data[29:0]};
				CFG_MOVE_LIMIT: p_move_limit = cfg.data;
				CFG_ANGLE_LIMIT: p_angle_limit = cfg.data;
				default: ;
			endcase
			cfg_pending = 0;
		end else if (cfg_pending && !cfg.valid) begin
			cfg.valid <= 1'b1;
			cfg.index <= cfg_index_q;
			cfg.data <= cfg_data_q;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready) ||
			(cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 200000) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		cfg_index_q = idx;
		cfg_data_q = val;
		cfg_pending = 1;
		while (cfg_pending) @(posedge clk);
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || sample.valid || expected_poses.size() != 0)
			@(posedge clk);
		repeat (800) @(posedge clk);
	endtask

	function automatic odo_item_t make_sample(logic [31:0] l, logic [31:0] r);
		odo_item_t it;
		it = '0;
		it.left_count = l;
		it.right_count = r;
		return it;
	endfunction

	function automatic odo_item_t make_load(logic [31:0] x, logic [31:0] y, logic [31:0] h);
		odo_item_t it;
		it = '0;
		it.command = 1;
		it.load_x = x;
		it.load_y = y;
		it.load_heading = h;
		it.left_count = $urandom;
		it.right_count = $urandom;
		return it;
	endfunction

	logic [31:0] run_left, run_right;

	task automatic add_random(int n);
		logic [31:0] step;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 8) begin
				int hsel;
				logic [31:0] hv;
				hsel = $urandom_range(3);
				hv = (hsel == 0) ? 32'sd1686629713 : (hsel == 1) ? -32'sd1686629713 :
					32'($signed($urandom_range(3373259426)) - 32'sd1686629713);
				pending_items.push_back(make_load($urandom, $urandom, hv));
			end else if ($urandom_range(99) < 5) begin
				run_left = $urandom;
				run_right = $urandom;
				pending_items.push_back(make_sample(run_left, run_right));
			end else begin
				case ($urandom_range(3))
					0: step = $urandom_range(200);
					1: step = $urandom_range(5000);
					2: step = -$urandom_range(5000);
					default: step = $urandom_range(100000) - 50000;
				endcase
				run_left += step;
				case ($urandom_range(3))
					0: run_right += step;
					1: run_right += step + $urandom_range(40) - 20;
					default: run_right += $urandom_range(10000) - 5000;
				endcase
				pending_items.push_back(make_sample(run_left, run_right));
			end
		end
	endtask

	initial begin
		int pct[4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{30, 30}};
		p_dist_per_count = 32'd4294967;
		p_wheel_base = 32'd33554432;
		p_straight_thr = 32'd912680;
		p_move_limit = 32'd6553600;
		p_angle_limit = 32'd268435456;
		{p_last_left, p_last_right, p_x, p_y, p_heading, p_travel, p_turn} = '0;
		run_left = 0;
		run_right = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at reset settings.
		pending_items.push_back(make_sample(0, 0));
		pending_items.push_back(make_sample(1000, 1000));
		pending_items.push_back(make_sample(1000, 3000));
		pending_items.push_back(make_sample(32'h7FFFFFFF, 32'h80000000));
		pending_items.push_back(make_sample(32'h80000000, 32'h7FFFFFFF));
		pending_items.push_back(make_sample(32'hFFFFFFFF, 32'hFFFFFFFF));
		pending_items.push_back(make_load(32'h7FFFFFFF, 32'h80000000, 32'sd1686629713));
		pending_items.push_back(make_sample(32'hFFFFFF00, 32'hFFFFFFFF));
		pending_items.push_back(make_load(32'h80000000, 32'h7FFFFFFF, -32'sd1686629713));
		pending_items.push_back(make_sample(32'hFFFFFE00, 32'hFFFFFFFF));
		pending_items.push_back(make_load(0, 0, 32'h7FFFFFFF));
		pending_items.push_back(make_sample(32'hFFFFFE00, 32'hFFFFFFFF));
		pending_items.push_back(make_load(0, 0, 32'h80000000));
		pending_items.push_back(make_sample(32'hFFFFFE10, 32'hFFFFFFEF));
		pending_items.push_back(make_sample(32'hFFFFFE10, 32'hFFFFFFEF));
		drain();

		// Extreme settings: zero wheel base, zero threshold, zero limits, largest distance per count.
		write_reg(CFG_WHEEL_BASE, 0);
		write_reg(CFG_STRAIGHT_THR, 0);
		write_reg(CFG_MOVE_LIMIT, 0);
		write_reg(CFG_ANGLE_LIMIT, 0);
		write_reg(CFG_DIST_PER_COUNT, 32'hFFFFFFFF);
		pending_items.push_back(make_sample(32'hFFFFFE10, 32'hFFFFFFEF));
		pending_items.push_back(make_sample(32'hFFFFFE11, 32'hFFFFFFEF));
		pending_items.push_back(make_sample(32'h7FFFFFFF, 32'h00000000));
		pending_items.push_back(make_sample(32'h00000000, 32'h00000000));
		drain();
		write_reg(CFG_WHEEL_BASE, 32'h7FFFFFFF);
		write_reg(CFG_STRAIGHT_THR, 32'd536870912);
		write_reg(CFG_MOVE_LIMIT, 32'hFFFFFFFF);
		write_reg(CFG_ANGLE_LIMIT, 32'hFFFFFFFF);
		write_reg(CFG_DIST_PER_COUNT, 1);
		pending_items.push_back(make_sample(32'h80000000, 32'h7FFFFFFF));
		pending_items.push_back(make_sample(32'h7FFFFFFF, 32'h80000000));
		drain();
		run_left = 32'h7FFFFFFF;
		run_right = 32'h80000000;

		for (int ph = 0; ph < 8; ph++) begin
			send_idle_pct = pct[ph % 4][0];
			recv_stall_pct = pct[ph % 4][1];
			write_reg(CFG_DIST_PER_COUNT, (ph % 3 == 0) ? 32'd4294967 : $urandom);
			write_reg(CFG_WHEEL_BASE, $urandom_range(32'h7FFFFFFF, 32'd65536));
			write_reg(CFG_STRAIGHT_THR, (ph == 5) ? 0 : $urandom_range(2000000));
			write_reg(CFG_MOVE_LIMIT, (ph % 2) ? $urandom : $urandom_range(20000000));
			write_reg(CFG_ANGLE_LIMIT, (ph % 2) ? $urandom : $urandom_range(600000000));
			add_random(RUN_ITEMS / 16);
			while (pending_items.size() > RUN_ITEMS / 32) @(posedge clk);
			if (ph == 2) begin
				hold_off = 1;
				while (sample.valid || expected_poses.size() != 0) @(posedge clk);
				hold_off = 0;
			end
			add_random(RUN_ITEMS / 16);
			drain();
		end

		if (!failed) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ddo_pkg.sv
hdl/ddo_if.sv
hdl/ddo_mul.sv
hdl/ddo_div.sv
hdl/ddo_sqrt.sv
hdl/ddo_cordic.sv
hdl/differential_drive_odometry_top.sv
verif/ddo_tb_if.sv
verif/tb.sv
